// ===== design/lfu_pkg.sv =====
// Package: shared types, constants and controller codes for the LFU table.
package lfu_pkg;
  localparam int Entries = 64;
  localparam int IdxW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);
  localparam int KeyW = 64;
  localparam int UseW = 48;
  localparam int CapW = 20;
  localparam int StampW = 64;
  localparam int MaxResults = 64;
  localparam int ResW = $clog2(MaxResults + 1);

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpTouch  = 2'd1;
  localparam logic [1:0] OpRemove = 2'd2;
  localparam logic [1:0] OpEvict  = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  typedef struct packed {
    logic [1:0]      operation;
    logic [KeyW-1:0] key;
    logic [31:0]     record_size;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            evicted_valid;
    logic [KeyW-1:0] evicted_key;
    logic [UseW-1:0] usage_bytes;
    logic            last;
  } res_t;

  // one slot of the entry memory; a larger stamp is a more recent use
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [31:0]       cnt;
    logic [31:0]       size;
    logic [StampW-1:0] stamp;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request, reset scan
    logic scan_step; // examine entry at scan index
    logic commit;    // apply the update decided by the scan
    logic ev_start;  // restart victim search
    logic evict;     // drop chosen victim
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic has_free;
    logic over;       // usage above limit and entries live
  } sts_t;
endpackage

// ===== design/lfu_replacement_table.sv =====
// Top level: LFU replacement table with oldest-first tie-break.
//
// Requests enter on in_valid_i/in_ready_o as one req_t item; results leave on
// out_valid_o/out_ready_i as res_t items. One request is processed at a time.
// Insert, touch and remove read all 64 entries from the entry memory, one per
// cycle, and then give one result; the next request is taken once that result
// has been loaded and the controller is back in idle.
// Evict runs the same scan per victim; at most 64 victims per request.
// Eviction results are held one deep so the final one can carry last;
// an evict that removes nothing gives a single result.
// capacity_mb_we_i writes the capacity; the user must do so only while idle, unchecked.
// Reset empties the table, clears usage and capacity; no clearing pass.
// When the receiver stalls, the result register holds; the next victim is scanned
// but not evicted until it drains; requests are refused until done.
module lfu_replacement_table (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  lfu_pkg::req_t            in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output lfu_pkg::res_t            out_data_o,
  input  logic                     capacity_mb_we_i,
  input  logic [lfu_pkg::CapW-1:0] capacity_mb_i
);
  import lfu_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  logic [CapW-1:0] cap_q;
  logic [KeyW-1:0] victim_key;
  logic [UseW-1:0] usage;
  logic            res_load, res_ev, res_last, res_flush;
  logic [1:0]      res_status;
  logic            hold_q, hold_d;    // eviction item held back awaiting its last flag
  res_t            held_q, held_d;
  res_t            out_q, out_d;
  res_t            new_res;
  logic            out_v_q, out_v_d;
  logic            res_free;
  logic            ctrl_done;

  assign res_free  = !out_v_q || out_ready_i;
  assign ctrl_done = (cmd == '0) && !res_load && !in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= '0;
    else if (capacity_mb_we_i) cap_q <= capacity_mb_i;
  end

  lfu_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i(in_data_i), .cap_i(cap_q),
    .sts_o(sts), .victim_key_o(victim_key), .usage_o(usage)
  );

  lfu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i(in_data_i.operation),
    .sts_i(sts), .cmd_o(cmd), .res_load_o(res_load), .res_status_o(res_status),
    .res_ev_o(res_ev), .res_last_o(res_last), .res_flush_o(res_flush),
    .res_free_i(res_free)
  );

  // usage after the action of this item
  always_comb begin
    new_res.status        = res_status;
    new_res.evicted_valid = res_ev;
    new_res.evicted_key   = res_ev ? victim_key : '0;
    new_res.usage_bytes   = usage;
    new_res.last          = res_last;
  end

  always_comb begin
    out_v_d = out_v_q && !out_ready_i;
    out_d   = out_q;
    hold_d  = hold_q;
    held_d  = held_q;
    if (res_load && res_ev) begin
      if (hold_q) begin
        out_v_d = 1'b1;
        out_d   = held_q;
      end
      hold_d = 1'b1;
      held_d = new_res;
    end else if (res_load) begin
      out_v_d = 1'b1;
      out_d   = new_res;
    end else if (res_flush) begin
      out_v_d    = 1'b1;
      out_d      = held_q;
      out_d.last = 1'b1;
      hold_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      hold_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      hold_q  <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    held_q <= held_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  ap_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !hold_q) else $error("held item while idle");
  ap_ev_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.evicted_valid |-> out_data_o.evicted_key == '0)
    else $error("stray evicted key");
  ap_ev_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StOk |-> out_data_o.last)
    else $error("error result not last");
  ap_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_done |-> !cmd.commit) else $error("commit while done");
endmodule

// ===== design/lfu_datapath.sv =====
// Datapath: entry memory, sequential scan, victim choice and usage total.
module lfu_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lfu_pkg::cmd_t            cmd_i,
  input  lfu_pkg::req_t            req_i,
  input  logic [lfu_pkg::CapW-1:0] cap_i,
  output lfu_pkg::sts_t            sts_o,
  output logic [lfu_pkg::KeyW-1:0] victim_key_o,
  output logic [lfu_pkg::UseW-1:0] usage_o
);
  import lfu_pkg::*;

  entry_t              mem [Entries];
  logic [Entries-1:0]  valid_q;
  logic [CntW-1:0]     live_q;
  logic [UseW-1:0]     usage_q;
  logic [StampW-1:0]   stamp_q;
  req_t                req_q;
  logic [CntW-1:0]     idx_q;
  logic                pend_q, rd_v_q;
  logic [IdxW-1:0]     rd_idx_q;
  entry_t              rd_q;
  logic                hit_q, free_q, best_v_q;
  logic [IdxW-1:0]     hit_idx_q, free_idx_q, best_q;
  entry_t              hit_e_q, best_e_q;

  logic            issue;
  logic            is_hit;
  logic            better;
  logic [IdxW-1:0] sel;
  logic [UseW-1:0] limit;
  logic [UseW-1:0] usage_nx;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  entry_t          wr_e;

  // one registered read per cycle; the entry is examined in the cycle after its read
  assign issue  = cmd_i.scan_step && (idx_q != CntW'(Entries));
  assign sel    = (req_q.operation == OpEvict) ? best_q : hit_idx_q;
  assign limit  = {8'd0, cap_i, 20'd0};
  assign is_hit = pend_q && rd_v_q && !hit_q && (rd_q.key == req_q.key);
  assign better = !best_v_q || (rd_q.cnt < best_e_q.cnt) ||
                  (rd_q.cnt == best_e_q.cnt && rd_q.stamp < best_e_q.stamp);

  assign wr_en  = cmd_i.commit && (req_q.operation != OpRemove);
  assign wr_idx = (req_q.operation == OpInsert && !hit_q) ? free_idx_q : hit_idx_q;

  always_comb begin
    wr_e.key   = req_q.key;
    wr_e.cnt   = 32'd1;
    wr_e.size  = req_q.record_size;
    wr_e.stamp = stamp_q;
    if (req_q.operation == OpTouch) begin
      wr_e.cnt  = (hit_e_q.cnt != '1) ? hit_e_q.cnt + 1'b1 : hit_e_q.cnt;
      wr_e.size = hit_e_q.size;
    end
  end

  // usage once the pending action of this item is applied
  always_comb begin
    usage_nx = usage_q;
    if (req_q.operation == OpEvict) begin
      if (best_v_q) usage_nx = usage_q - UseW'(best_e_q.size);
    end else if (hit_q) begin
      if (req_q.operation == OpRemove) usage_nx = usage_q - UseW'(hit_e_q.size);
      else if (req_q.operation == OpInsert)
        usage_nx = usage_q - UseW'(hit_e_q.size) + UseW'(req_q.record_size);
    end else if (req_q.operation == OpInsert && free_q) begin
      usage_nx = usage_q + UseW'(req_q.record_size);
    end
  end

  assign sts_o.scan_done = (idx_q == CntW'(Entries)) && !pend_q;
  assign sts_o.found     = (req_q.operation == OpEvict) ? best_v_q : hit_q;
  assign sts_o.has_free  = free_q;
  assign sts_o.over      = (usage_q > limit) && (live_q != '0);
  assign victim_key_o    = best_e_q.key;
  assign usage_o         = usage_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      live_q   <= '0;
      usage_q  <= '0;
      stamp_q  <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      best_v_q <= 1'b0;
    end else begin
      pend_q <= issue;
      if (cmd_i.load || cmd_i.ev_start) begin
        idx_q    <= '0;
        hit_q    <= 1'b0;
        free_q   <= 1'b0;
        best_v_q <= 1'b0;
      end else begin
        if (issue) idx_q <= idx_q + 1'b1;
        if (is_hit) hit_q <= 1'b1;
        if (pend_q && rd_v_q && better) best_v_q <= 1'b1;
        if (pend_q && !rd_v_q) free_q <= 1'b1;
      end
      if (cmd_i.evict || (cmd_i.commit && req_q.operation == OpRemove)) begin
        valid_q[sel] <= 1'b0;
        live_q       <= live_q - 1'b1;
      end else if (cmd_i.commit && req_q.operation == OpInsert && !hit_q) begin
        valid_q[free_idx_q] <= 1'b1;
        live_q              <= live_q + 1'b1;
      end
      if (cmd_i.commit || cmd_i.evict) usage_q <= usage_nx;
      if (wr_en) stamp_q <= stamp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (issue) begin
      rd_q     <= mem[idx_q[IdxW-1:0]];
      rd_v_q   <= valid_q[idx_q[IdxW-1:0]];
      rd_idx_q <= idx_q[IdxW-1:0];
    end
    if (wr_en) mem[wr_idx] <= wr_e;
    if (is_hit) begin
      hit_idx_q <= rd_idx_q;
      hit_e_q   <= rd_q;
    end
    if (pend_q && rd_v_q && better) begin
      best_q   <= rd_idx_q;
      best_e_q <= rd_q;
    end
    if (pend_q && !rd_v_q && !free_q) free_idx_q <= rd_idx_q;
  end
endmodule

// ===== design/lfu_ctrl.sv =====
// Controller: sequences scan, update, victim loop and result hand-off.
module lfu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  lfu_pkg::sts_t      sts_i,
  output lfu_pkg::cmd_t      cmd_o,
  output logic               res_load_o,
  output logic [1:0]         res_status_o,
  output logic               res_ev_o,
  output logic               res_last_o,
  output logic               res_flush_o,
  input  logic               res_free_i
);
  import lfu_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;
  localparam logic [2:0] SDec   = 3'd2;
  localparam logic [2:0] SEvChk = 3'd3;
  localparam logic [2:0] SEvOut = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [1:0]      op_q;
  logic [ResW-1:0] n_q, n_d;

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    cmd_o        = '0;
    res_load_o   = 1'b0;
    res_status_o = StOk;
    res_ev_o     = 1'b0;
    res_last_o   = 1'b1;
    res_flush_o  = 1'b0;
    case (state_q)
      SIdle: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        n_d        = '0;
        state_d    = (op_i == OpEvict) ? SEvChk : SScan;
      end
      SScan: begin
        if (sts_i.scan_done) state_d = SDec;
        else cmd_o.scan_step = 1'b1;
      end
      SDec: if (res_free_i) begin
        res_load_o = 1'b1;
        if (op_q == OpInsert && !sts_i.found && !sts_i.has_free) res_status_o = StFull;
        else if (op_q != OpInsert && !sts_i.found) res_status_o = StNotFound;
        else cmd_o.commit = 1'b1;
        state_d = SIdle;
      end
      SEvChk: begin
        if (sts_i.over && n_q != ResW'(MaxResults)) begin
          cmd_o.ev_start = 1'b1;
          state_d = SEvOut;
        end else begin
          state_d = SDone;
        end
      end
      SEvOut: begin
        if (!sts_i.scan_done) cmd_o.scan_step = 1'b1;
        else if (res_free_i) begin
          cmd_o.evict = 1'b1;
          res_load_o  = 1'b1;
          res_ev_o    = 1'b1;
          res_last_o  = 1'b0;
          n_d         = n_q + 1'b1;
          state_d     = SEvChk;
        end
      end
      SDone: if (res_free_i) begin
        // terminal result; a held eviction result gets its last flag instead
        res_load_o  = (n_q == '0);
        res_flush_o = (n_q != '0);
        state_d     = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      n_q     <= '0;
      op_q    <= OpInsert;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      if (cmd_o.load) op_q <= op_i;
    end
  end
endmodule
